[rtl/fcfo_pkg.sv]
// Shared types, widths and constants for the fine CFO pilot correlator.
// No dependencies; every other file refers to it by scoped names.
package fcfo_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int PROD_W     = 32;
	localparam int ACC_W      = 48;
	// 48-bit sum after the quadrant fold grows by the CORDIC gain (< 2.4x)
	localparam int CORD_W     = 50;
	localparam int PHASE_W    = 16;
	localparam int FFT_W      = 14;
	localparam int SYMLEN_W   = 15;
	localparam int CFO_W      = 20;
	localparam int NUM_W      = PHASE_W + FFT_W + 1;
	localparam int DIVD_W     = 31;
	localparam int DIVS_W     = SYMLEN_W + 1;
	localparam int ATAN_IDX_W = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FFT_SIZE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LENGTH = 1'b1;

	localparam logic [FFT_W-1:0]    FFT_SIZE_RST      = 14'd64;
	localparam logic [SYMLEN_W-1:0] SYMBOL_LENGTH_RST = 15'd80;

	localparam logic signed [CFO_W-1:0] CFO_MAX = 20'sh7FFFF;
	localparam logic signed [CFO_W-1:0] CFO_MIN = 20'sh80000;
	// largest quotient magnitudes that still fit each side
	localparam logic [DIVD_W-1:0] QUO_POS_LIM = 31'd524287;
	localparam logic [DIVD_W-1:0] QUO_NEG_LIM = 31'd524288;

	localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'd16384;

	typedef struct packed {
		logic ready;   // can take a pilot pair this cycle
		logic idle;    // all products folded into the accumulator
	} mac_stat_t;

	// atan(2^-i) in units of pi/32768, rounded
	function automatic logic [PHASE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [PHASE_W-1:0] r;
		case (idx)
			5'd0:    r = 16'd8192;
			5'd1:    r = 16'd4836;
			5'd2:    r = 16'd2555;
			5'd3:    r = 16'd1297;
			5'd4:    r = 16'd651;
			5'd5:    r = 16'd326;
			5'd6:    r = 16'd163;
			5'd7:    r = 16'd81;
			5'd8:    r = 16'd41;
			5'd9:    r = 16'd20;
			5'd10:   r = 16'd10;
			5'd11:   r = 16'd5;
			5'd12:   r = 16'd3;
			5'd13:   r = 16'd1;
			5'd14:   r = 16'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/fcfo_if.sv]
// Channel interfaces of the fine CFO pilot correlator: pilot pairs in,
// results out, register writes. Depends on fcfo_pkg.
interface fcfo_pilot_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] sym1_re;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] sym1_im;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] sym2_re;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] sym2_im;
	logic                                  last;

	modport source (output valid, sym1_re, sym1_im, sym2_re, sym2_im, last, input ready);
	modport sink   (input valid, sym1_re, sym1_im, sym2_re, sym2_im, last, output ready);
endinterface

interface fcfo_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [fcfo_pkg::CFO_W-1:0]   cfo;
	logic signed [fcfo_pkg::PHASE_W-1:0] phase;
	logic                               saturated;

	modport source (output valid, cfo, phase, saturated, input ready);
	modport sink   (input valid, cfo, phase, saturated, output ready);
endinterface

interface fcfo_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [fcfo_pkg::CFG_IDX_W-1:0]  index;
	logic [fcfo_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fcfo_mac.sv]
// Complex multiply-accumulate of sym2 * conj(sym1) on one shared 16x16 multiplier,
// four products per pair, 48-bit wrapping sums. Depends on fcfo_pkg.
module fcfo_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  clear,
	input  logic signed [fcfo_pkg::SAMPLE_W-1:0] a_re,
	input  logic signed [fcfo_pkg::SAMPLE_W-1:0] a_im,
	input  logic signed [fcfo_pkg::SAMPLE_W-1:0] b_re,
	input  logic signed [fcfo_pkg::SAMPLE_W-1:0] b_im,
	output fcfo_pkg::mac_stat_t                   stat,
	output logic signed [fcfo_pkg::ACC_W-1:0]    acc_re,
	output logic signed [fcfo_pkg::ACC_W-1:0]    acc_im
);

	localparam logic [1:0] PROD_RR = 2'd0;  // b_re * a_re -> re
	localparam logic [1:0] PROD_II = 2'd1;  // b_im * a_im -> re
	localparam logic [1:0] PROD_IR = 2'd2;  // b_im * a_re -> im
	localparam logic [1:0] PROD_RI = 2'd3;  // b_re * a_im -> im, subtracted

	logic                                  busy_q;
	logic [1:0]                            step_q;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
	logic signed [fcfo_pkg::SAMPLE_W-1:0] op_a, op_b;
	logic signed [fcfo_pkg::PROD_W-1:0]   prod_s1;
	logic [1:0]                            sel_s1;
	logic                                  pv_s1;
	logic signed [fcfo_pkg::ACC_W-1:0]    prod_ext;
	logic signed [fcfo_pkg::ACC_W-1:0]    acc_re_q, acc_im_q;

	assign stat.ready = !busy_q || (step_q == PROD_RI);
	assign stat.idle  = !busy_q && !pv_s1;
	assign acc_re     = acc_re_q;
	assign acc_im     = acc_im_q;

	always_comb begin
		unique case (step_q)
			PROD_RR: begin op_a = b_re_q; op_b = a_re_q; end
			PROD_II: begin op_a = b_im_q; op_b = a_im_q; end
			PROD_IR: begin op_a = b_im_q; op_b = a_re_q; end
			PROD_RI: begin op_a = b_re_q; op_b = a_im_q; end
		endcase
	end

	assign prod_ext = fcfo_pkg::ACC_W'(prod_s1);

	always_ff @(posedge clk) begin
		if (start) begin
			a_re_q <= a_re;
			a_im_q <= a_im;
			b_re_q <= b_re;
			b_im_q <= b_im;
		end
		prod_s1 <= op_a * op_b;
		sel_s1  <= step_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			step_q   <= PROD_RR;
			pv_s1    <= 1'b0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else begin
			pv_s1 <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= PROD_RR;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == PROD_RI)
					busy_q <= 1'b0;
			end

			if (clear) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else if (pv_s1) begin
				unique case (sel_s1)
					PROD_RR, PROD_II: acc_re_q <= acc_re_q + prod_ext;
					PROD_IR:          acc_im_q <= acc_im_q + prod_ext;
					PROD_RI:          acc_im_q <= acc_im_q - prod_ext;
				endcase
			end
		end
	end

endmodule

[rtl/fcfo_cordic.sv]
// Iterative vectoring CORDIC: one shift-add step per cycle gives the angle of
// the correlation sum in units of pi/32768. Depends on fcfo_pkg.
module fcfo_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [fcfo_pkg::ACC_W-1:0]    x_in,
	input  logic signed [fcfo_pkg::ACC_W-1:0]    y_in,
	output logic                                  done,
	output logic signed [fcfo_pkg::PHASE_W-1:0]  phase
);

	localparam int IW = $clog2(STEPS);
	localparam logic [IW-1:0] LAST_STEP = IW'(STEPS - 1);

	logic signed [fcfo_pkg::CORD_W-1:0] xin_w, yin_w, x0, y0;
	logic signed [fcfo_pkg::CORD_W-1:0] x_q, y_q, dx, dy;
	logic [fcfo_pkg::PHASE_W-1:0]       z0, z_q, at;
	logic [IW-1:0]                      i_q;
	logic                               busy_q, zero_q, done_q;

	assign xin_w = fcfo_pkg::CORD_W'(x_in);
	assign yin_w = fcfo_pkg::CORD_W'(y_in);

	// fold the left half plane onto the right with a quarter turn
	always_comb begin
		x0 = xin_w;
		y0 = yin_w;
		z0 = '0;
		if (xin_w[fcfo_pkg::CORD_W-1]) begin
			if (!yin_w[fcfo_pkg::CORD_W-1]) begin
				x0 = yin_w;
				y0 = -xin_w;
				z0 = fcfo_pkg::QUARTER_TURN;
			end else begin
				x0 = -yin_w;
				y0 = xin_w;
				z0 = -fcfo_pkg::QUARTER_TURN;
			end
		end
	end

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = fcfo_pkg::atan_entry(fcfo_pkg::ATAN_IDX_W'(i_q));

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x0;
			y_q    <= y0;
			z_q    <= z0;
			zero_q <= (x_in == '0) && (y_in == '0);
		end else if (busy_q) begin
			if (!y_q[fcfo_pkg::CORD_W-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (i_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + IW'(1);
				if (i_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	assign done  = done_q;
	assign phase = zero_q ? '0 : $signed(z_q);

endmodule

[rtl/fcfo_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, for the offset
// normalization. Depends on fcfo_pkg.
module fcfo_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [fcfo_pkg::DIVD_W-1:0]     dividend,
	input  logic [fcfo_pkg::DIVS_W-1:0]     divisor,
	output logic                            done,
	output logic [fcfo_pkg::DIVD_W-1:0]     quotient
);

	localparam int CW = $clog2(fcfo_pkg::DIVD_W);
	localparam logic [CW-1:0] LAST_BIT = CW'(fcfo_pkg::DIVD_W - 1);

	logic [fcfo_pkg::DIVD_W-1:0] num_q, quo_q;
	logic [fcfo_pkg::DIVS_W-1:0] den_q, rem_q;
	logic [fcfo_pkg::DIVS_W:0]   trial, diff;
	logic                        fits;
	logic [CW-1:0]               cnt_q;
	logic                        busy_q, done_q;

	assign trial = {rem_q, num_q[fcfo_pkg::DIVD_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[fcfo_pkg::DIVS_W-1:0] : trial[fcfo_pkg::DIVS_W-1:0];
			quo_q <= {quo_q[fcfo_pkg::DIVD_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_BIT);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST_BIT)
					busy_q <= 1'b0;
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[rtl/fine_cfo_pilot_correlator.sv]
// Top level of the fine CFO pilot correlator: register file, result sequencer
// and output register. Depends on fcfo_pkg, fcfo_if, fcfo_mac, fcfo_cordic, fcfo_div.
//
//   channel  dir  handshake       payload
//   pilot    in   valid / ready   sym1_re, sym1_im, sym2_re, sym2_im, last
//   result   out  valid / ready   cfo, phase, saturated
//   cfg      in   valid / ready   index, data (ready is always high)
//
// Pilot pairs without last share the one 16x16 multiplier, which forms four partial
// products per pair; the next pair is taken as the fourth product of the one before starts.
// A pair with last closes the input until its result is loaded: the four products,
// the drain of the product pipe, the angle, scale, check, the divide and the load of
// the output register; the divide is skipped when the angle times fft_size is zero
// or symbol_length is zero.
// The result sits in an output register, so pairs keep flowing while it waits;
// a second result holds the block in ST_DONE until the first is taken.
// Reset clears the accumulator and restores fft_size 64 and symbol_length 80.
module fine_cfo_pilot_correlator #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	fcfo_pilot_if.sink    pilot,
	fcfo_result_if.source result,
	fcfo_cfg_if.sink      cfg
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DRAIN  = 7'b0000010,
		ST_CORDIC = 7'b0000100,
		ST_SCALE  = 7'b0001000,
		ST_CHECK  = 7'b0010000,
		ST_DIV    = 7'b0100000,
		ST_DONE   = 7'b1000000
	} state_t;

	state_t                                state_q;
	logic [fcfo_pkg::FFT_W-1:0]            fft_q;
	logic [fcfo_pkg::SYMLEN_W-1:0]         symlen_q;
	fcfo_pkg::mac_stat_t                   mac_stat;
	logic signed [fcfo_pkg::ACC_W-1:0]     acc_re, acc_im;
	logic                                  pilot_acc;
	logic                                  cord_start, cord_done;
	logic signed [fcfo_pkg::PHASE_W-1:0]   cord_phase, phase_q;
	logic signed [fcfo_pkg::NUM_W-1:0]     num_q, mag;
	logic                                  neg;
	logic                                  div_start, div_done;
	logic [fcfo_pkg::DIVD_W-1:0]           dividend, quotient;
	logic [fcfo_pkg::DIVS_W-1:0]           divisor;
	logic signed [fcfo_pkg::CFO_W-1:0]     res_cfo_q;
	logic                                  res_sat_q;
	logic                                  out_valid_q;
	logic signed [fcfo_pkg::CFO_W-1:0]     out_cfo_q;
	logic signed [fcfo_pkg::PHASE_W-1:0]   out_phase_q;
	logic                                  out_sat_q;
	logic                                  out_load;

	assign pilot.ready = (state_q == ST_IDLE) && mac_stat.ready;
	assign pilot_acc   = pilot.valid && pilot.ready;
	assign cfg.ready   = 1'b1;

	assign cord_start = (state_q == ST_DRAIN) && mac_stat.idle;
	assign div_start  = (state_q == ST_CHECK) && (num_q != '0) && (symlen_q != '0);
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	fcfo_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pilot_acc),
		.clear  (cord_start),
		.a_re   (pilot.sym1_re),
		.a_im   (pilot.sym1_im),
		.b_re   (pilot.sym2_re),
		.b_im   (pilot.sym2_im),
		.stat   (mac_stat),
		.acc_re (acc_re),
		.acc_im (acc_im)
	);

	fcfo_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.x_in   (acc_re),
		.y_in   (acc_im),
		.done   (cord_done),
		.phase  (cord_phase)
	);

	// round half away from zero: (2|num| + L) / 2L
	assign neg      = num_q[fcfo_pkg::NUM_W-1];
	assign mag      = neg ? -num_q : num_q;
	assign dividend = (fcfo_pkg::DIVD_W'(mag) << 1) + fcfo_pkg::DIVD_W'(symlen_q);
	assign divisor  = {symlen_q, 1'b0};

	fcfo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fft_q    <= fcfo_pkg::FFT_SIZE_RST;
			symlen_q <= fcfo_pkg::SYMBOL_LENGTH_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fcfo_pkg::REG_FFT_SIZE:      fft_q    <= cfg.data[fcfo_pkg::FFT_W-1:0];
				fcfo_pkg::REG_SYMBOL_LENGTH: symlen_q <= cfg.data[fcfo_pkg::SYMLEN_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CORDIC && cord_done)
			phase_q <= cord_phase;
		if (state_q == ST_SCALE)
			num_q <= phase_q * $signed({1'b0, fft_q});
		if (state_q == ST_CHECK) begin
			res_sat_q <= symlen_q == '0 && num_q != '0;
			res_cfo_q <= num_q == '0 ? '0 : (neg ? fcfo_pkg::CFO_MIN : fcfo_pkg::CFO_MAX);
		end
		if (state_q == ST_DIV && div_done) begin
			if (!neg) begin
				res_sat_q <= quotient > fcfo_pkg::QUO_POS_LIM;
				res_cfo_q <= quotient > fcfo_pkg::QUO_POS_LIM ? fcfo_pkg::CFO_MAX
				                                              : $signed(quotient[fcfo_pkg::CFO_W-1:0]);
			end else begin
				res_sat_q <= quotient > fcfo_pkg::QUO_NEG_LIM;
				res_cfo_q <= quotient > fcfo_pkg::QUO_NEG_LIM ? fcfo_pkg::CFO_MIN
				             : $signed(fcfo_pkg::CFO_W'(0) - quotient[fcfo_pkg::CFO_W-1:0]);
			end
		end
		if (out_load) begin
			out_cfo_q   <= res_cfo_q;
			out_phase_q <= phase_q;
			out_sat_q   <= res_sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE:   if (pilot_acc && pilot.last) state_q <= ST_DRAIN;
				ST_DRAIN:  if (mac_stat.idle) state_q <= ST_CORDIC;
				ST_CORDIC: if (cord_done) state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_CHECK;
				ST_CHECK:  state_q <= div_start ? ST_DIV : ST_DONE;
				ST_DIV:    if (div_done) state_q <= ST_DONE;
				ST_DONE:   if (out_load) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid     = out_valid_q;
	assign result.cfo       = out_cfo_q;
	assign result.phase     = out_phase_q;
	assign result.saturated = out_sat_q;

endmodule

[rtl/fcfo_checker.sv]
// Port-level checks for the fine CFO pilot correlator, bound to the top level.
// Depends on fcfo_pkg and fine_cfo_pilot_correlator.
module fcfo_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  in_last,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [fcfo_pkg::CFO_W-1:0]     cfo,
	input logic signed [fcfo_pkg::PHASE_W-1:0]   phase,
	input logic                                  saturated
);

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cfo) && $stable(phase)
		                            && $stable(saturated))
		else $error("result changed while stalled");

	// a closing item shuts the input once it is taken
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input open right after a closing item");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> cfo == fcfo_pkg::CFO_MAX || cfo == fcfo_pkg::CFO_MIN)
		else $error("saturated offset not at a rail");

	a_zero_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase == '0 |-> cfo == '0 && !saturated)
		else $error("zero angle gave nonzero offset");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && phase[fcfo_pkg::PHASE_W-1] |-> cfo[fcfo_pkg::CFO_W-1] || cfo == '0)
		else $error("offset sign disagrees with angle");

endmodule

bind fine_cfo_pilot_correlator fcfo_checker u_fcfo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pilot.valid),
	.in_ready  (pilot.ready),
	.in_last   (pilot.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.cfo       (result.cfo),
	.phase     (result.phase),
	.saturated (result.saturated)
);

[tb/tb_top.sv]
// Self-checking bench for fine_cfo_pilot_correlator: drives pilot pairs and register writes,
// predicts each offset estimate and compares it with the block's result channel.
// Depends on rtl/fcfo_pkg.sv, rtl/fcfo_if.sv and the correlator RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORDIC_N   = 16;
	localparam int DRAIN_CYC  = 80;     // settling wait of wait_drain after the last estimate
	localparam int HALF_SET   = 128;
	localparam int CFO_HI     = 524287;
	localparam int CFO_LO     = -524288;
	localparam int ATAN_TBL[CORDIC_N] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	typedef struct {
		logic signed [fcfo_pkg::SAMPLE_W-1:0] s1_re;
		logic signed [fcfo_pkg::SAMPLE_W-1:0] s1_im;
		logic signed [fcfo_pkg::SAMPLE_W-1:0] s2_re;
		logic signed [fcfo_pkg::SAMPLE_W-1:0] s2_im;
		logic                                 last;
	} pilot_pair_t;

	typedef struct {
		logic signed [fcfo_pkg::CFO_W-1:0]   cfo;
		logic signed [fcfo_pkg::PHASE_W-1:0] phase;
		logic                                sat;
	} offset_est_t;

	logic clk;
	logic arst_n;

	fcfo_pilot_if  pilot_ch ();
	fcfo_result_if result_ch ();
	fcfo_cfg_if    cfg_ch ();

	fine_cfo_pilot_correlator #(.CORDIC_STEPS(CORDIC_N)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pilot  (pilot_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	logic signed [fcfo_pkg::ACC_W-1:0] acc_re;
	logic signed [fcfo_pkg::ACC_W-1:0] acc_im;
	logic [fcfo_pkg::FFT_W-1:0]        fft_size_q;
	logic [fcfo_pkg::SYMLEN_W-1:0]     sym_len_q;
	offset_est_t                       pending_estimates[$];

	int mismatch_cnt;
	int result_cnt;
	bit no_gaps;
	bit rx_steady;
	int rx_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("fine_cfo_pilot_correlator regression: fail");
		$finish;
	end

	// ---------------- prediction ----------------

	function automatic logic signed [fcfo_pkg::PHASE_W-1:0] vector_angle(longint x, longint y);
		logic [fcfo_pkg::PHASE_W-1:0] z;
		longint t;
		longint dx;
		longint dy;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		// fold the left half plane onto the right one
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = 16'h4000;
			end else begin
				x = -y;
				y = t;
				z = 16'hC000;
			end
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + fcfo_pkg::PHASE_W'(ATAN_TBL[i]);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - fcfo_pkg::PHASE_W'(ATAN_TBL[i]);
			end
		end
		return signed'(z);
	endfunction

	function automatic void fold_pair(pilot_pair_t p);
		longint pr;
		longint pim;
		longint num;
		longint mag;
		longint len;
		longint q;
		longint cfo_v;
		offset_est_t e;
		pr  = longint'(p.s2_re) * longint'(p.s1_re) + longint'(p.s2_im) * longint'(p.s1_im);
		pim = longint'(p.s2_im) * longint'(p.s1_re) - longint'(p.s2_re) * longint'(p.s1_im);
		acc_re = acc_re + fcfo_pkg::ACC_W'(pr);
		acc_im = acc_im + fcfo_pkg::ACC_W'(pim);
		if (!p.last)
			return;
		e.phase = vector_angle(longint'(acc_re), longint'(acc_im));
		e.sat = 1'b0;
		num = longint'(e.phase) * longint'(fft_size_q);
		if (num == 0) begin
			cfo_v = 0;
		end else if (sym_len_q == '0) begin
			cfo_v = (num < 0) ? CFO_LO : CFO_HI;
			e.sat = 1'b1;
		end else begin
			mag = (num < 0) ? -num : num;
			len = longint'(sym_len_q);
			q = (2 * mag + len) / (2 * len);
			cfo_v = (num < 0) ? -q : q;
			if (cfo_v > CFO_HI) begin
				cfo_v = CFO_HI;
				e.sat = 1'b1;
			end
			if (cfo_v < CFO_LO) begin
				cfo_v = CFO_LO;
				e.sat = 1'b1;
			end
		end
		e.cfo = cfo_v[fcfo_pkg::CFO_W-1:0];
		pending_estimates.push_back(e);
		acc_re = '0;
		acc_im = '0;
	endfunction

	// ---------------- result side ----------------

	task automatic log_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		offset_est_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			result_cnt++;
			if (pending_estimates.size() == 0) begin
				log_mismatch($sformatf("result %0d with nothing expected: cfo %0d phase %0d sat %0b",
					result_cnt, result_ch.cfo, result_ch.phase, result_ch.saturated));
			end else begin
				want = pending_estimates.pop_front();
				if (result_ch.cfo !== want.cfo || result_ch.phase !== want.phase ||
						result_ch.saturated !== want.sat)
					log_mismatch($sformatf(
						"result %0d: cfo exp %0d got %0d, phase exp %0d got %0d, sat exp %0b got %0b",
						result_cnt, want.cfo, result_ch.cfo, want.phase, result_ch.phase,
						want.sat, result_ch.saturated));
			end
		end
	end

	// receiver: random stalls, a counted hold-off on request, or steady ready
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				result_ch.ready <= 1'b0;
				rx_hold--;
			end else if (rx_steady) begin
				result_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 9) < 7) begin
				result_ch.ready <= 1'b1;
			end else begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic pilot_pair_t mk_pair(int s1r, int s1i, int s2r, int s2i, bit lst);
		pilot_pair_t p;
		p.s1_re = fcfo_pkg::SAMPLE_W'(s1r);
		p.s1_im = fcfo_pkg::SAMPLE_W'(s1i);
		p.s2_re = fcfo_pkg::SAMPLE_W'(s2r);
		p.s2_im = fcfo_pkg::SAMPLE_W'(s2i);
		p.last  = lst;
		return p;
	endfunction

	function automatic logic signed [fcfo_pkg::SAMPLE_W-1:0] rand_sample();
		logic signed [fcfo_pkg::SAMPLE_W-1:0] r;
		case ($urandom_range(0, 9))
			0:       r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1:       r = fcfo_pkg::SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			default: r = fcfo_pkg::SAMPLE_W'($urandom);
		endcase
		return r;
	endfunction

	function automatic pilot_pair_t rand_pair(bit lst);
		pilot_pair_t p;
		p.s1_re = rand_sample();
		p.s1_im = rand_sample();
		p.s2_re = rand_sample();
		p.s2_im = rand_sample();
		p.last  = lst;
		return p;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_pair(pilot_pair_t p);
		int gap;
		pilot_ch.valid   <= 1'b1;
		pilot_ch.sym1_re <= p.s1_re;
		pilot_ch.sym1_im <= p.s1_im;
		pilot_ch.sym2_re <= p.s2_re;
		pilot_ch.sym2_im <= p.s2_im;
		pilot_ch.last    <= p.last;
		do @(posedge clk); while (!pilot_ch.ready);
		fold_pair(p);
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			pilot_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, wait for every estimate, then let the block settle
	task automatic wait_drain();
		pilot_ch.valid <= 1'b0;
		while (pending_estimates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [fcfo_pkg::CFG_IDX_W-1:0] idx,
			logic [fcfo_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == fcfo_pkg::REG_FFT_SIZE)
			fft_size_q = val[fcfo_pkg::FFT_W-1:0];
		else
			sym_len_q = val[fcfo_pkg::SYMLEN_W-1:0];
	endtask

	task automatic set_scaling(logic [fcfo_pkg::CFG_DATA_W-1:0] fft_val,
			logic [fcfo_pkg::CFG_DATA_W-1:0] len_val);
		write_reg(fcfo_pkg::REG_FFT_SIZE, fft_val);
		write_reg(fcfo_pkg::REG_SYMBOL_LENGTH, len_val);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_set(int n);
		for (int i = 0; i < n; i++)
			send_pair(rand_pair(i == n - 1));
	endtask

	// ---------------- tests ----------------

	// reset scaling; zero sum, each axis, the second and third quadrants, full-scale samples
	task automatic test_angles();
		send_pair(mk_pair(0, 0, 0, 0, 1));
		send_pair(mk_pair(32767, 0, 32767, 0, 1));
		send_pair(mk_pair(32767, 0, 0, 32767, 1));
		send_pair(mk_pair(32767, 0, 0, -32768, 1));
		send_pair(mk_pair(32767, 0, -32768, 0, 1));
		send_pair(mk_pair(32767, 0, -32768, -1, 1));
		send_pair(mk_pair(-32768, -32768, -32768, -32768, 1));
		send_pair(mk_pair(32767, -32768, -32768, 32767, 1));
		send_pair(mk_pair(-1, 1, 1, -1, 0));
		send_pair(mk_pair(32767, -32768, 1, -1, 0));
		send_pair(mk_pair(-32768, 32767, 12345, -23456, 1));
		wait_drain();
	endtask

	// scaling extremes: saturation, zero symbol length, zero fft size, ratio limits
	task automatic test_scaling();
		logic [fcfo_pkg::CFG_DATA_W-1:0] fft_vals[6] = '{16'hFFFF, 16'hC040, 16'h0000,
			16'd8192, 16'd64, 16'd64};
		logic [fcfo_pkg::CFG_DATA_W-1:0] len_vals[6] = '{16'h0001, 16'h8000, 16'h7FFF,
			16'd64, 16'd16384, 16'd80};
		for (int k = 0; k < 6; k++) begin
			set_scaling(fft_vals[k], len_vals[k]);
			send_pair(mk_pair(32767, 0, -32768, 100, 1));
			send_pair(mk_pair(32767, 0, -32768, -100, 1));
			wait_drain();
		end
	endtask

	task automatic test_random_sets();
		int sent;
		int n;
		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 4))
				0:       set_scaling(fcfo_pkg::CFG_DATA_W'($urandom),
						fcfo_pkg::CFG_DATA_W'($urandom));
				1:       set_scaling($urandom_range(0, 1) ? 16'd8192 : 16'd64,
						$urandom_range(0, 1) ? 16'd16384 : 16'd64);
				default: set_scaling(fcfo_pkg::CFG_DATA_W'($urandom_range(64, 8192)),
						fcfo_pkg::CFG_DATA_W'($urandom_range(64, 16384)));
			endcase
			no_gaps   = (ph % 4 == 3);
			rx_steady = (ph % 4 == 3);
			sent = 0;
			while (sent < 110) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
				send_set(n);
				sent += n;
			end
			wait_drain();
		end
		no_gaps   = 1'b0;
		rx_steady = 1'b0;
	endtask

	// results held off long enough that the output register fills and the input stalls
	task automatic test_backpressure();
		no_gaps = 1'b1;
		rx_hold = 400;
		for (int i = 0; i < 60; i++)
			send_pair(rand_pair(i % 6 == 5));
		no_gaps = 1'b0;
		wait_drain();
		// sender pauses with one set in flight, then resumes
		send_set(3);
		wait_drain();
		send_set(4);
		wait_drain();
	endtask

	// long sets of full-scale pairs add near-largest per-pair products into the accumulator
	task automatic test_acc_full();
		set_scaling(16'd64, 16'd80);
		no_gaps = 1'b1;
		for (int i = 0; i < HALF_SET; i++)
			send_pair(mk_pair(-32768, -32768, -32768, -32768, i == HALF_SET - 1));
		for (int i = 0; i < HALF_SET; i++)
			send_pair(mk_pair(32767, -32768, -32768, 32767, i == HALF_SET - 1));
		no_gaps = 1'b0;
		wait_drain();
	endtask

	initial begin
		arst_n           <= 1'b0;
		pilot_ch.valid   <= 1'b0;
		pilot_ch.sym1_re <= '0;
		pilot_ch.sym1_im <= '0;
		pilot_ch.sym2_re <= '0;
		pilot_ch.sym2_im <= '0;
		pilot_ch.last    <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= fcfo_pkg::REG_FFT_SIZE;
		cfg_ch.data      <= '0;
		acc_re       = '0;
		acc_im       = '0;
		fft_size_q   = fcfo_pkg::FFT_SIZE_RST;
		sym_len_q    = fcfo_pkg::SYMBOL_LENGTH_RST;
		mismatch_cnt = 0;
		result_cnt   = 0;
		no_gaps      = 1'b0;
		rx_steady    = 1'b0;
		rx_hold      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_angles();
		test_scaling();
		test_random_sets();
		test_backpressure();
		test_acc_full();

		if (mismatch_cnt == 0)
			$display("fine_cfo_pilot_correlator regression: pass");
		else
			$display("fine_cfo_pilot_correlator regression: fail");
		$finish;
	end

endmodule
